### sv/array_double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// array double-ended queue assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define ADQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adq assertion failed");

// next-cycle implication
`define ADQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adq assertion failed");

`endif

### sv/adq_pkg.sv
// ----------------------------------------------------------------------------
// adq_pkg
// types and constants of the array double-ended queue
// ----------------------------------------------------------------------------
package adq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = $clog2(DEPTH) + 1;
  localparam int MODE_W = 3;
  localparam int DATA_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int STS_W = 2;
  localparam int CMP_W = (PTR_W > POS_W) ? PTR_W : POS_W;

  typedef enum logic [MODE_W-1:0] {
    MD_PUSH_REAR  = 3'd0,
    MD_PUSH_FRONT = 3'd1,
    MD_POP_FRONT  = 3'd2,
    MD_POP_REAR   = 3'd3,
    MD_PEEK       = 3'd4
  } mode_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_OUT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

endpackage

### sv/adq_ctrl.sv
// ----------------------------------------------------------------------------
// adq_ctrl
// sequencer: accept one item, execute it, hold the result until transfer
// ----------------------------------------------------------------------------
module adq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output adq_pkg::ctl_cmd_t cmd
);

  adq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adq_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      adq_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = adq_pkg::CS_EXEC;
        end
      end
      adq_pkg::CS_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = adq_pkg::CS_OUT;
      end
      adq_pkg::CS_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = adq_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = adq_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

### sv/adq_datapath.sv
// ----------------------------------------------------------------------------
// adq_datapath
// item register, head and tail pointers, slot memory and result register
// ----------------------------------------------------------------------------
module adq_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  adq_pkg::ctl_cmd_t                cmd,
  input  logic [adq_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [adq_pkg::DATA_W-1:0] in_value,
  input  logic [adq_pkg::POS_W-1:0]        in_position,
  output logic [adq_pkg::STS_W-1:0]        out_status,
  output logic signed [adq_pkg::DATA_W-1:0] out_data,
  output logic [adq_pkg::CNT_W-1:0]        out_count
);

  localparam int IDX_W = adq_pkg::IDX_W;
  localparam int PTR_W = adq_pkg::PTR_W;
  localparam int CMP_W = adq_pkg::CMP_W;

  logic [adq_pkg::MODE_W-1:0]        mode_r;
  logic signed [adq_pkg::DATA_W-1:0] value_r;
  logic [adq_pkg::POS_W-1:0]         position_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] cnt;
  logic [PTR_W-1:0] cnt_new;
  logic [PTR_W-1:0] peek_sum;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_new_ext;
  logic             settle;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] addr;

  adq_pkg::status_t status_nxt;

  logic [adq_pkg::STS_W-1:0]         status_r;
  logic [adq_pkg::CNT_W-1:0]         count_r;
  logic                              rd_flag_r;
  logic signed [adq_pkg::DATA_W-1:0] rd_data_r;

  logic signed [adq_pkg::DATA_W-1:0] slots [adq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_mode;
      value_r    <= in_value;
      position_r <= in_position;
    end
  end

  always_comb begin
    cnt        = tail_r - head_r;
    pos_ext    = CMP_W'(position_r);
    cnt_ext    = CMP_W'(cnt);
    peek_sum   = head_r + PTR_W'(position_r) - PTR_W'(1);
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = adq_pkg::ST_OK;
    settle     = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    addr       = '0;
    case (adq_pkg::mode_t'(mode_r))
      adq_pkg::MD_PUSH_REAR: begin
        if (tail_r >= PTR_W'(adq_pkg::DEPTH)) begin
          status_nxt = adq_pkg::ST_NO_ROOM;
        end else begin
          wr_en    = 1'b1;
          addr     = tail_r[IDX_W-1:0];
          tail_nxt = tail_r + PTR_W'(1);
        end
      end
      adq_pkg::MD_PUSH_FRONT: begin
        if (head_r == '0) begin
          status_nxt = adq_pkg::ST_NO_ROOM;
        end else begin
          head_nxt = head_r - PTR_W'(1);
          wr_en    = 1'b1;
          addr     = head_nxt[IDX_W-1:0];
        end
      end
      adq_pkg::MD_POP_FRONT: begin
        settle = 1'b1;
        if (cnt == '0) begin
          status_nxt = adq_pkg::ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          addr     = head_r[IDX_W-1:0];
          head_nxt = head_r + PTR_W'(1);
        end
      end
      adq_pkg::MD_POP_REAR: begin
        settle = 1'b1;
        if (cnt == '0) begin
          status_nxt = adq_pkg::ST_EMPTY;
        end else begin
          tail_nxt = tail_r - PTR_W'(1);
          rd_en    = 1'b1;
          addr     = tail_nxt[IDX_W-1:0];
        end
      end
      adq_pkg::MD_PEEK: begin
        if (cnt == '0) begin
          status_nxt = adq_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_nxt = adq_pkg::ST_BAD_POS;
        end else begin
          rd_en = 1'b1;
          addr  = peek_sum[IDX_W-1:0];
        end
      end
      default: begin
        status_nxt = adq_pkg::ST_OK;
      end
    endcase
    if (settle && head_nxt >= tail_nxt) begin
      head_nxt = '0;
      tail_nxt = '0;
    end
    cnt_new     = tail_nxt - head_nxt;
    cnt_new_ext = CMP_W'(cnt_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      count_r   <= cnt_new_ext[adq_pkg::CNT_W-1:0];
      rd_flag_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      slots[addr] <= value_r;
    end
    if (cmd.exec && rd_en) begin
      rd_data_r <= slots[addr];
    end
  end

  assign out_status = status_r;
  assign out_count  = count_r;
  assign out_data   = rd_flag_r ? rd_data_r : '0;

endmodule

### sv/array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// array_double_ended_queue
// linear array double-ended queue with push and pop at both ends and peek
//
//   channel   ports                                 transfer
//   in        in_mode, in_value, in_position        in_valid & in_ready
//   out       out_status, out_data, out_count       out_valid & out_ready
//
// the item is registered at its input transfer; in the exec state it is executed against
// the pointers and the single-port slot memory, and the result is offered in
// the next cycle. the next item is taken only in the idle state after the
// result transfer, so the block takes no new item before the last result is out.
// reset is synchronous and clears the head and tail pointers; slot contents stay
// undefined until written. a stalled result holds the block.
// ----------------------------------------------------------------------------
`include "array_double_ended_queue_macros.svh"

module array_double_ended_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [adq_pkg::MODE_W-1:0]       in_mode,
  input  logic signed [adq_pkg::DATA_W-1:0] in_value,
  input  logic [adq_pkg::POS_W-1:0]        in_position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [adq_pkg::STS_W-1:0]        out_status,
  output logic signed [adq_pkg::DATA_W-1:0] out_data,
  output logic [adq_pkg::CNT_W-1:0]        out_count
);

  adq_pkg::ctl_cmd_t cmd;

  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  adq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_mode     (in_mode),
    .in_value    (in_value),
    .in_position (in_position),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

  `ADQ_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready && cmd.exec)
  `ADQ_ASSERT_NXT(a_result_follows, cmd.exec, out_valid)
  `ADQ_ASSERT_IMP(a_fail_no_data, out_valid && out_status != adq_pkg::ST_OK, out_data == '0)
  `ADQ_ASSERT_IMP(a_count_bound, out_valid, out_count <= adq_pkg::CNT_W'(adq_pkg::DEPTH))

endmodule

### bench/tb_array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_array_double_ended_queue
// self-checking bench for the linear array double-ended queue: directed
// corner cases on the empty and full queue, then biased random traffic that
// fills and drains both ends, with random gaps on input and result channels
// except in a final back-to-back run; every result transfer is compared with
// an in-bench prediction of the deque
module tb_array_double_ended_queue;

  localparam int LIMIT = 400000;

  typedef struct {
    logic [adq_pkg::STS_W-1:0]  status;
    logic [adq_pkg::DATA_W-1:0] data;
    logic [adq_pkg::CNT_W-1:0]  count;
  } deque_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [adq_pkg::MODE_W-1:0]        in_mode;
  logic signed [adq_pkg::DATA_W-1:0] in_value;
  logic [adq_pkg::POS_W-1:0]         in_position;
  logic                              out_valid;
  logic                              out_ready;
  logic [adq_pkg::STS_W-1:0]         out_status;
  logic signed [adq_pkg::DATA_W-1:0] out_data;
  logic [adq_pkg::CNT_W-1:0]         out_count;

  // predicted deque contents
  logic [adq_pkg::DATA_W-1:0] q_slots [adq_pkg::DEPTH];
  int unsigned                q_head;
  int unsigned                q_tail;

  deque_result_t pending_results [$];
  int            err_cnt;
  int            cycle_cnt;
  bit            idle_on;

  array_double_ended_queue u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_value    (in_value),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("** array_double_ended_queue: FAILED **");
      $finish;
    end
  end

  function automatic deque_result_t deque_predict(logic [adq_pkg::MODE_W-1:0] m,
                                                  logic [adq_pkg::DATA_W-1:0] v,
                                                  logic [adq_pkg::POS_W-1:0] p);
    deque_result_t r;
    int unsigned   cnt;
    r.status = adq_pkg::ST_OK;
    r.data   = '0;
    cnt      = q_tail - q_head;
    case (m)
      adq_pkg::MD_PUSH_REAR: begin
        if (q_tail >= adq_pkg::DEPTH) begin
          r.status = adq_pkg::ST_NO_ROOM;
        end else begin
          q_slots[q_tail] = v;
          q_tail++;
        end
      end
      adq_pkg::MD_PUSH_FRONT: begin
        if (q_head == 0) begin
          r.status = adq_pkg::ST_NO_ROOM;
        end else begin
          q_head--;
          q_slots[q_head] = v;
        end
      end
      adq_pkg::MD_POP_FRONT, adq_pkg::MD_POP_REAR: begin
        if (cnt == 0) begin
          r.status = adq_pkg::ST_EMPTY;
        end else if (m == adq_pkg::MD_POP_FRONT) begin
          r.data = q_slots[q_head];
          q_head++;
        end else begin
          q_tail--;
          r.data = q_slots[q_tail];
        end
        // pointers go back to the origin once empty
        if (q_head >= q_tail) begin
          q_head = 0;
          q_tail = 0;
        end
      end
      adq_pkg::MD_PEEK: begin
        if (cnt == 0) begin
          r.status = adq_pkg::ST_EMPTY;
        end else if (p == 0 || p > cnt) begin
          r.status = adq_pkg::ST_BAD_POS;
        end else begin
          r.data = q_slots[q_head + p - 1];
        end
      end
      default: begin
      end
    endcase
    r.count = adq_pkg::CNT_W'(q_tail - q_head);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [adq_pkg::MODE_W-1:0] m,
                           input logic [adq_pkg::DATA_W-1:0] v,
                           input logic [adq_pkg::POS_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_value    <= v;
    in_position <= p;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(deque_predict(m, v, p));
  endtask

  // result side: random stalls
  initial begin
    int n;
    int g;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer status %0d data %0d count %0d",
                 $time, out_status, out_data, out_count);
        err_cnt++;
      end else begin
        deque_result_t e;
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $display("%0t status expected %0d actual %0d", $time, e.status, out_status);
          err_cnt++;
        end
        if (out_data !== e.data) begin
          $display("%0t data expected %0d actual %0d", $time, $signed(e.data), out_data);
          err_cnt++;
        end
        if (out_count !== e.count) begin
          $display("%0t count expected %0d actual %0d", $time, e.count, out_count);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [adq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [adq_pkg::POS_W-1:0] pick_position();
    int unsigned cnt;
    int          r;
    cnt = q_tail - q_head;
    r   = $urandom_range(0, 9);
    if (cnt > 0 && r < 8) return adq_pkg::POS_W'($urandom_range(1, cnt));
    if (r == 8) return (cnt == 0 || $urandom_range(0, 1)) ? '0 : adq_pkg::POS_W'(cnt + 1);
    return adq_pkg::POS_W'($urandom_range(0, 31));
  endfunction

  task automatic test_empty_queue();
    send_item(adq_pkg::MD_POP_FRONT, pick_value(), 5'd1);
    send_item(adq_pkg::MD_POP_REAR, pick_value(), 5'd1);
    send_item(adq_pkg::MD_PEEK, pick_value(), 5'd1);
    send_item(adq_pkg::MD_PUSH_FRONT, 32'h1234_5678, 5'd0);
    send_item(3'd5, 32'hffff_ffff, 5'd31);
    send_item(3'd7, 32'h8000_0000, 5'd16);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < adq_pkg::DEPTH; i++) begin
      send_item(adq_pkg::MD_PUSH_REAR, (i == 0) ? 32'h8000_0000 :
                (i == 1) ? 32'h7fff_ffff : $urandom, 5'($urandom));
    end
    send_item(adq_pkg::MD_PUSH_REAR, 32'hdead_beef, 5'd0);
    send_item(adq_pkg::MD_PEEK, 32'h0, 5'd0);
    send_item(adq_pkg::MD_PEEK, 32'h0, 5'd16);
    send_item(adq_pkg::MD_PEEK, 32'h0, 5'd17);
    send_item(adq_pkg::MD_POP_FRONT, 32'h0, 5'd0);
    send_item(adq_pkg::MD_PUSH_FRONT, 32'hffff_ffff, 5'd0);
    send_item(adq_pkg::MD_POP_REAR, 32'h0, 5'd0);
  endtask

  task automatic test_random_traffic(input int num_items);
    bit fill_bias;
    int run_left;
    int r;
    logic [adq_pkg::MODE_W-1:0] m;
    fill_bias = 1'b0;
    run_left  = 0;
    for (int i = 0; i < num_items; i++) begin
      if (run_left == 0) begin
        fill_bias = ~fill_bias;
        run_left  = $urandom_range(10, 40);
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        m = adq_pkg::MODE_W'($urandom_range(5, 7));
      end else begin
        r = $urandom_range(0, 99);
        if (fill_bias) begin
          m = (r < 50) ? adq_pkg::MD_PUSH_REAR : (r < 70) ? adq_pkg::MD_PUSH_FRONT :
              (r < 85) ? adq_pkg::MD_PEEK : (r < 93) ? adq_pkg::MD_POP_FRONT :
              adq_pkg::MD_POP_REAR;
        end else begin
          m = (r < 15) ? adq_pkg::MD_PUSH_REAR : (r < 25) ? adq_pkg::MD_PUSH_FRONT :
              (r < 45) ? adq_pkg::MD_PEEK : (r < 72) ? adq_pkg::MD_POP_FRONT :
              adq_pkg::MD_POP_REAR;
        end
      end
      send_item(m, pick_value(), pick_position());
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_traffic(120);
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = '0;
    in_value    = '0;
    in_position = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    idle_on     = 1'b1;
    q_head      = 0;
    q_tail      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_full_queue();
    test_random_traffic(880);
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** array_double_ended_queue: PASSED **");
    end else begin
      $display("** array_double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/adq_pkg.sv
sv/adq_ctrl.sv
sv/adq_datapath.sv
sv/array_double_ended_queue.sv
bench/tb_array_double_ended_queue.sv
